/* rtl/sobm_pkg.sv */
// Package for the RGB Sobel edge magnitude core: types, constants, helper functions.
package sobm_pkg;

  localparam int unsigned DefMaxWidth    = 1024;
  localparam logic [10:0] DefFrameWidth  = 11'd640;
  localparam logic [15:0] DefFrameHeight = 16'd480;
  localparam logic [20:0] SatLimit       = 21'd65280;
  localparam logic [7:0]  SatValue       = 8'd255;

  // configuration register indexes
  localparam logic CfgFrameWidth  = 1'b0;
  localparam logic CfgFrameHeight = 1'b1;

  // item kinds carried on tuser
  localparam logic OpPixel = 1'b0;
  localparam logic OpFlush = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SHIFT,
    ST_GRAD,
    ST_SQUARE,
    ST_ROOT,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic accept;
    logic shift;
    logic grad;
    logic square;
    logic root;
    logic load;
  } cmd_t;

  typedef struct packed {
    logic drop;
    logic emit;
    logic root_last;
    logic out_free;
  } status_t;

  typedef logic [8:0][7:0] win_t;

  // weighted column/row difference of one 3x3 channel window
  function automatic logic signed [10:0] grad_x(win_t p);
    logic [9:0] a;
    logic [9:0] b;
    a = 10'(p[2]) + 10'({p[5], 1'b0}) + 10'(p[8]);
    b = 10'(p[0]) + 10'({p[3], 1'b0}) + 10'(p[6]);
    return $signed({1'b0, a}) - $signed({1'b0, b});
  endfunction

  function automatic logic signed [10:0] grad_y(win_t p);
    logic [9:0] a;
    logic [9:0] b;
    a = 10'(p[6]) + 10'({p[7], 1'b0}) + 10'(p[8]);
    b = 10'(p[0]) + 10'({p[1], 1'b0}) + 10'(p[2]);
    return $signed({1'b0, a}) - $signed({1'b0, b});
  endfunction

  function automatic logic [9:0] abs11(logic signed [10:0] v);
    logic signed [10:0] n;
    n = -v;
    return v[10] ? n[9:0] : v[9:0];
  endfunction

endpackage

/* rtl/sobm_ctrl.sv */
// Controller state machine sequencing one word through the edge datapath.
module sobm_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  sobm_pkg::status_t status,
  output sobm_pkg::cmd_t   cmd
);

  sobm_pkg::state_t state;
  sobm_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sobm_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    case (state)
      sobm_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.accept = 1'b1;
          if (!status.drop) state_next = sobm_pkg::ST_SHIFT;
        end
      end
      sobm_pkg::ST_SHIFT: begin
        cmd.shift  = 1'b1;
        state_next = status.emit ? sobm_pkg::ST_GRAD : sobm_pkg::ST_IDLE;
      end
      sobm_pkg::ST_GRAD: begin
        cmd.grad   = 1'b1;
        state_next = sobm_pkg::ST_SQUARE;
      end
      sobm_pkg::ST_SQUARE: begin
        cmd.square = 1'b1;
        state_next = sobm_pkg::ST_ROOT;
      end
      sobm_pkg::ST_ROOT: begin
        cmd.root = 1'b1;
        if (status.root_last) state_next = sobm_pkg::ST_FINISH;
      end
      sobm_pkg::ST_FINISH: begin
        if (status.out_free) begin
          cmd.load   = 1'b1;
          state_next = sobm_pkg::ST_IDLE;
        end
      end
      default: state_next = sobm_pkg::ST_IDLE;
    endcase
  end

endmodule

/* rtl/sobm_dp.sv */
// Datapath: line stores, window, position counters, gradients, root unit, output register.
module sobm_dp #(
  parameter int unsigned MAX_WIDTH = sobm_pkg::DefMaxWidth
) (
  input  logic              clk,
  input  logic              rst,
  input  sobm_pkg::cmd_t    cmd,
  output sobm_pkg::status_t status,
  input  logic [23:0]       s_tdata,
  input  logic              s_tuser,
  input  logic              cfg_valid,
  input  logic              cfg_index,
  input  logic [15:0]       cfg_data,
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [23:0]       m_tdata,
  output logic              m_tlast
);

  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned WW = $clog2(MAX_WIDTH + 1);

  // configuration
  logic [10:0] frame_width;
  logic [15:0] frame_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= sobm_pkg::DefFrameWidth;
      frame_height <= sobm_pkg::DefFrameHeight;
    end else if (cfg_valid) begin
      if (cfg_index == sobm_pkg::CfgFrameWidth) frame_width <= cfg_data[10:0];
      else frame_height <= cfg_data;
    end
  end

  logic [WW-1:0] eff_w;
  logic [15:0]   eff_h;

  always_comb begin
    if (frame_width == 11'd0) eff_w = WW'(1);
    else if (32'(frame_width) > 32'(MAX_WIDTH)) eff_w = WW'(MAX_WIDTH);
    else eff_w = WW'(frame_width);
    eff_h = (frame_height == 16'd0) ? 16'd1 : frame_height;
  end

  // position counters
  logic [CW-1:0] in_column;
  logic [16:0]   in_row;
  logic [CW-1:0] out_column;
  logic [15:0]   out_row;

  logic draining;
  assign draining = in_row >= 17'(eff_h);

  // latched input word
  logic [23:0] pix;

  always_ff @(posedge clk) begin
    if (cmd.accept) pix <= s_tdata;
  end

  // line stores, registered read at accept, write during shift
  logic [23:0] upper_mem [MAX_WIDTH];
  logic [23:0] middle_mem [MAX_WIDTH];
  logic [23:0] rd_up;
  logic [23:0] rd_mid;
  logic [23:0] newpix;

  assign newpix = draining ? 24'd0 : pix;

  always_ff @(posedge clk) begin
    if (cmd.accept) rd_up <= upper_mem[in_column];
    if (cmd.shift) upper_mem[in_column] <= rd_mid;
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) rd_mid <= middle_mem[in_column];
    if (cmd.shift) middle_mem[in_column] <= newpix;
  end

  // 3x3 window, index = row*3 + column
  logic [8:0][23:0] win;

  always_ff @(posedge clk) begin
    if (rst) begin
      win <= '0;
    end else if (cmd.shift) begin
      win[0] <= win[1];
      win[1] <= win[2];
      win[2] <= rd_up;
      win[3] <= win[4];
      win[4] <= win[5];
      win[5] <= rd_mid;
      win[6] <= win[7];
      win[7] <= win[8];
      win[8] <= newpix;
    end
  end

  // emit decision and frame border flags
  logic emit;
  logic in_col_end;
  logic out_col_end;
  logic out_row_end;
  logic last;

  assign emit        = (in_row >= 17'd2) || (in_row == 17'd1 && in_column != '0);
  assign in_col_end  = (WW'(in_column) + WW'(1)) >= eff_w;
  assign out_col_end = (WW'(out_column) + WW'(1)) >= eff_w;
  assign out_row_end = (17'(out_row) + 17'd1) >= 17'(eff_h);
  assign last        = out_row_end && out_col_end;

  logic m_top, m_bot, m_lft, m_rgt, last_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_column  <= '0;
      in_row     <= '0;
      out_column <= '0;
      out_row    <= '0;
    end else if (cmd.shift) begin
      if (emit && last) begin
        in_column  <= '0;
        in_row     <= '0;
        out_column <= '0;
        out_row    <= '0;
      end else begin
        if (in_col_end) begin
          in_column <= '0;
          if (in_row != 17'h1FFFF) in_row <= in_row + 17'd1;
        end else begin
          in_column <= in_column + CW'(1);
        end
        if (emit) begin
          if (out_col_end) begin
            out_column <= '0;
            out_row    <= out_row + 16'd1;
          end else begin
            out_column <= out_column + CW'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.shift) begin
      m_top  <= out_row == 16'd0;
      m_bot  <= out_row_end;
      m_lft  <= out_column == '0;
      m_rgt  <= out_col_end;
      last_q <= last;
    end
  end

  // per-channel gradients, squares and root
  logic [2:0][9:0]  ax;
  logic [2:0][9:0]  ay;
  logic [2:0][20:0] sum;
  logic [2:0][7:0]  root;
  logic [2:0][7:0]  res;
  logic [2:0]       root_hit;
  logic [2:0][7:0]  root_try;
  logic [2:0]       root_mask;
  logic [2:0][7:0]  masked;
  logic [2:0][16:0] fsq;
  logic [2:0]       sat;
  logic [2:0]       rnd;
  logic [2:0]       root_idx;
  sobm_pkg::win_t   cw [3];

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      for (int k = 0; k < 9; k++) begin
        if ((k < 3 && m_top) || (k > 5 && m_bot) || (k % 3 == 0 && m_lft) ||
            (k % 3 == 2 && m_rgt)) begin
          cw[ch][k] = 8'd0;
        end else begin
          cw[ch][k] = win[k][8*ch +: 8];
        end
      end
    end
  end

  assign masked = {3{8'd1 << root_idx}};

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      root_try[ch] = root[ch] | masked[ch];
      root_hit[ch] = 21'(16'(root_try[ch]) * 16'(root_try[ch])) <= sum[ch];
      fsq[ch]      = 17'(root[ch]) * 17'(root[ch]) + 17'(root[ch]);
      sat[ch]      = sum[ch] > sobm_pkg::SatLimit;
      rnd[ch]      = sum[ch] > 21'(fsq[ch]);
      res[ch]      = sat[ch] ? sobm_pkg::SatValue : (rnd[ch] ? root[ch] + 8'd1 : root[ch]);
      root_mask[ch] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    for (int ch = 0; ch < 3; ch++) begin
      if (cmd.grad) begin
        ax[ch] <= sobm_pkg::abs11(sobm_pkg::grad_x(cw[ch]));
        ay[ch] <= sobm_pkg::abs11(sobm_pkg::grad_y(cw[ch]));
      end
      if (cmd.square) begin
        sum[ch]  <= 21'(20'(ax[ch]) * 20'(ax[ch])) + 21'(20'(ay[ch]) * 20'(ay[ch]));
        root[ch] <= 8'd0;
      end else if (cmd.root && root_hit[ch]) begin
        root[ch] <= root_try[ch] | {7'd0, root_mask[ch]};
      end
    end
  end

  // root bit counter, one result bit per cycle from the top
  always_ff @(posedge clk) begin
    if (rst) root_idx <= 3'd7;
    else if (cmd.square) root_idx <= 3'd7;
    else if (cmd.root) root_idx <= root_idx - 3'd1;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      m_tdata <= {res[2], res[1], res[0]};
      m_tlast <= last_q;
    end
  end

  assign status.drop      = (s_tuser == sobm_pkg::OpFlush) && !draining;
  assign status.emit      = emit;
  assign status.root_last = root_idx == 3'd0;
  assign status.out_free  = !m_tvalid || m_tready;

endmodule

/* rtl/sobel_edge_magnitude_rgb_core.sv */
// Top level of the RGB Sobel edge magnitude core.
// Input stream: one word per pixel in raster order; s_tuser = 0 for a pixel,
// 1 for a flush word. A result leaves frame_width+1 words after the pixel it
// belongs to, so after a frame's last pixel frame_width+1 flush words drain
// the remaining results. Flush words inside a frame are taken and dropped.
// Output stream: per-channel round(sqrt(Gx^2+Gy^2)) saturated to 255, with
// m_tlast high on the result of the frame's last pixel; neighbors outside the
// frame count as zero.
// Config channel: index 0 = frame_width (11 bits), 1 = frame_height (16 bits);
// write only while the core is idle.
// Sequence: a word that yields no result goes through line store read and window
// shift; a word that yields a result goes through line store read, window shift,
// gradient, square, eight steps of the bit-per-cycle root unit and output load.
// A dropped flush word is only accepted. A new word is taken only once the last is done.
// Reset: counters and window clear, registers return to 640 x 480; line stores
// are not cleared. When the receiver stalls, a finished result waits in the
// output register while the next word is already accepted and worked on.
module sobel_edge_magnitude_rgb_core #(
  parameter int unsigned MAX_WIDTH = sobm_pkg::DefMaxWidth
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // red[7:0], green[15:8], blue[23:16]
  input  logic        s_tuser,   // op
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // edge_red[7:0], edge_green[15:8], edge_blue[23:16]
  output logic        m_tlast,   // frame_last
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);

  sobm_pkg::cmd_t    cmd;
  sobm_pkg::status_t status;

  assign cfg_ready = 1'b1;

  sobm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  sobm_dp #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

endmodule
